// ----- design/lad_pkg.sv -----
// Package for the linear-array deque: operation and status codes, and the
// result bundle passed from the index control to the top level.
// No dependencies.
package lad_pkg;

  localparam int CAP_W = 7;
  localparam int DATA_W = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_END   = 3'd1,
    OP_DEL_FRONT = 3'd2,
    OP_DEL_END   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_END  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL_FRONT = 2'd1,
    ST_FULL_END   = 2'd2,
    ST_UNDERFLOW  = 2'd3
  } status_t;

  typedef struct packed {
    status_t status;
    logic    is_empty;
    logic    is_full;
    logic    peek;
  } res_t;

endpackage

// ----- design/lad_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/lad_ctrl.sv -----
// Index control of the deque: front/rear indices, empty flag, capacity register,
// next-state rules per operation and the RAM access they cause. Uses lad_pkg.
module lad_ctrl #(
  parameter int DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           acc,
  input  logic [2:0]                     op,
  input  logic [lad_pkg::DATA_W-1:0]     value_in,
  input  logic                           capacity_we,
  input  logic [lad_pkg::CAP_W-1:0]      capacity_in_use,
  output logic                           ram_we,
  output logic [$clog2(DEPTH)-1:0]       ram_waddr,
  output logic [lad_pkg::DATA_W-1:0]     ram_wdata,
  output logic [$clog2(DEPTH)-1:0]       ram_raddr,
  output lad_pkg::res_t                  res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = (AW + 1 > lad_pkg::CAP_W) ? AW + 1 : lad_pkg::CAP_W;

  logic [AW-1:0] front, front_next;
  logic [AW-1:0] rear, rear_next;
  logic          empty, empty_next;
  logic [lad_pkg::CAP_W-1:0] capacity;

  logic [CW-1:0] cap_ext;
  logic [CW-1:0] cap_m1;
  logic [AW-1:0] span;
  logic          wr;

  // Clamp the capacity register to 1..DEPTH, then take the limit on rear.
  always_comb begin
    cap_ext = CW'(capacity);
    if (cap_ext == '0) begin
      cap_m1 = '0;
    end else if (cap_ext > CW'(DEPTH)) begin
      cap_m1 = CW'(DEPTH - 1);
    end else begin
      cap_m1 = cap_ext - CW'(1);
    end
  end

  always_comb begin
    front_next = front;
    rear_next  = rear;
    empty_next = empty;
    wr         = 1'b0;
    ram_waddr  = front;
    ram_raddr  = front;
    res.status = lad_pkg::ST_OK;
    res.peek   = 1'b0;
    case (lad_pkg::op_t'(op))
      lad_pkg::OP_INS_FRONT: begin
        if (empty || front == '0) begin
          res.status = lad_pkg::ST_FULL_FRONT;
        end else begin
          front_next = front - AW'(1);
          wr         = 1'b1;
          ram_waddr  = front - AW'(1);
        end
      end
      lad_pkg::OP_INS_END: begin
        if (empty) begin
          // restart at slot 0
          front_next = '0;
          rear_next  = '0;
          empty_next = 1'b0;
          wr         = 1'b1;
          ram_waddr  = '0;
        end else if (CW'(rear) >= cap_m1) begin
          res.status = lad_pkg::ST_FULL_END;
        end else begin
          rear_next = rear + AW'(1);
          wr        = 1'b1;
          ram_waddr = rear + AW'(1);
        end
      end
      lad_pkg::OP_DEL_FRONT, lad_pkg::OP_DEL_END: begin
        if (empty) begin
          res.status = lad_pkg::ST_UNDERFLOW;
        end else if (front == rear) begin
          front_next = '0;
          rear_next  = '0;
          empty_next = 1'b1;
        end else if (lad_pkg::op_t'(op) == lad_pkg::OP_DEL_FRONT) begin
          front_next = front + AW'(1);
        end else begin
          rear_next = rear - AW'(1);
        end
      end
      lad_pkg::OP_PEEK_FRONT: begin
        res.peek  = !empty;
        ram_raddr = front;
      end
      lad_pkg::OP_PEEK_END: begin
        res.peek  = !empty;
        ram_raddr = rear;
      end
      default: begin
      end
    endcase
    span         = rear_next - front_next;
    res.is_empty = empty_next;
    res.is_full  = !empty_next && (CW'(span) >= cap_m1);
  end

  assign ram_we    = acc && wr;
  assign ram_wdata = value_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      front    <= '0;
      rear     <= '0;
      empty    <= 1'b1;
      capacity <= lad_pkg::CAP_RESET;
    end else begin
      if (acc) begin
        front <= front_next;
        rear  <= rear_next;
        empty <= empty_next;
      end
      if (capacity_we) begin
        capacity <= capacity_in_use;
      end
    end
  end

endmodule

// ----- design/linear_array_deque.sv -----
// Double-ended queue held in a linear, non-wrapping array. One request
// (insert, delete or peek at either end) is accepted per clock cycle when
// start is high and busy is low; its result appears with done in the next
// cycle, value_out coming from the registered read port of the element RAM.
// Every request yields one result and the receiver cannot stall, so the rate
// is one request per cycle. busy is set by reset and cleared once it ends.
// Depends on lad_pkg, lad_ctrl and lad_ram.
module linear_array_deque #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 op,
  input  logic signed [31:0]         value_in,
  input  logic                       capacity_we,
  input  logic [6:0]                 capacity_in_use,
  output logic                       done,
  output logic [1:0]                 status,
  output logic signed [31:0]         value_out,
  output logic                       is_empty,
  output logic                       is_full
);

  localparam int AW = $clog2(DEPTH);

  logic                          acc;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [AW-1:0]                 ram_raddr;
  logic [lad_pkg::DATA_W-1:0]    ram_wdata;
  logic [lad_pkg::DATA_W-1:0]    ram_rdata;
  lad_pkg::res_t                 res_next;
  lad_pkg::res_t                 res;

  assign acc = start && !busy;

  lad_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .acc             (acc),
    .op              (op),
    .value_in        (value_in),
    .capacity_we     (capacity_we),
    .capacity_in_use (capacity_in_use),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_raddr       (ram_raddr),
    .res             (res_next)
  );

  lad_ram #(
    .WIDTH (lad_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else begin
      busy <= 1'b0;
      done <= acc;
    end
  end

  // Hold the result bits alongside the RAM read of the same request.
  always_ff @(posedge clk) begin
    if (acc) begin
      res <= res_next;
    end
  end

  assign status    = res.status;
  assign is_empty  = res.is_empty;
  assign is_full   = res.is_full;
  assign value_out = res.peek ? ram_rdata : '1;

endmodule

// ----- design/lad_checker.sv -----
// Port-level checks for linear_array_deque, attached by the bind below.
// Depends on lad_pkg.
module lad_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [1:0]         status,
  input logic signed [31:0] value_out,
  input logic               is_empty,
  input logic               is_full
);

  // Every result follows a transfer in the cycle before.
  a_done_follows_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result without a preceding request");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    (done && status == lad_pkg::ST_UNDERFLOW) |-> is_empty)
    else $error("underflow reported on a non-empty deque");

  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    (done && is_full) |-> !is_empty)
    else $error("deque reported both full and empty");

  a_refused_no_value: assert property (@(posedge clk) disable iff (rst)
    (done && status != lad_pkg::ST_OK) |-> (value_out == -32'sd1))
    else $error("refused request returned a value");

endmodule

bind linear_array_deque lad_checker u_lad_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .status    (status),
  .value_out (value_out),
  .is_empty  (is_empty),
  .is_full   (is_full)
);
